### design/eagle2x_pkg.sv
`default_nettype none

package eagle2x_pkg;

    // fixed field widths of the stream and configuration port
    localparam int COL_BITS        = 10;
    localparam int ROW_BITS        = 12;
    localparam int WIDTH_REG_BITS  = 11;
    localparam int HEIGHT_REG_BITS = 13;
    localparam int CFG_DATA_BITS   = 13;
    localparam int CFG_ADDR_BITS   = 1;

    localparam int HEIGHT_MAX   = 4096;
    localparam int WIDTH_RESET  = 1024;
    localparam int HEIGHT_RESET = 1024;

    // result queue between the block stage and the output port
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

    // corner order inside a 2x2 output block
    localparam int NUM_CORNERS = 4;
    localparam int CORNER_TL   = 0;
    localparam int CORNER_TR   = 1;
    localparam int CORNER_BL   = 2;
    localparam int CORNER_BR   = 3;

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_FLUSH = 1'b1
    } t_opcode;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } t_reg_index;

    typedef struct packed {
        logic [1:0] push_count;
        logic       pop;
    } t_fifo_ctl;

endpackage

`default_nettype wire

### design/eagle2x_line_ram.sv
`default_nettype none

module eagle2x_line_ram #(
    parameter int DEPTH     = 1024,
    parameter int DATA_BITS = 24
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [DATA_BITS-1:0]     i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [DATA_BITS-1:0]     o_rdata_a,
    output logic      [DATA_BITS-1:0]     o_rdata_b
);

    logic [DATA_BITS-1:0] r_mem [DEPTH];

    // read-first: a read of the address written in the same cycle returns the old entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

`default_nettype wire

### design/eagle2x_kernel.sv
`default_nettype none

module eagle2x_kernel #(
    parameter int PIXEL_BITS = 24
) (
    // neighbourhood indexed [row][column], row 0 above, column 0 left
    input  wire logic [2:0][2:0][PIXEL_BITS-1:0]                   i_nb,
    output logic      [eagle2x_pkg::NUM_CORNERS-1:0][PIXEL_BITS-1:0] o_corner
);

    logic [PIXEL_BITS-1:0] a, b, c, d, e, f, g, h, i;

    assign a = i_nb[0][0];
    assign b = i_nb[0][1];
    assign c = i_nb[0][2];
    assign d = i_nb[1][0];
    assign e = i_nb[1][1];
    assign f = i_nb[1][2];
    assign g = i_nb[2][0];
    assign h = i_nb[2][1];
    assign i = i_nb[2][2];

    // a corner takes the diagonal pixel when it matches both edge neighbours on that side
    always_comb begin
        o_corner[eagle2x_pkg::CORNER_TL] = (d == a && a == b) ? a : e;
        o_corner[eagle2x_pkg::CORNER_TR] = (b == c && c == f) ? c : e;
        o_corner[eagle2x_pkg::CORNER_BL] = (d == g && g == h) ? g : e;
        o_corner[eagle2x_pkg::CORNER_BR] = (h == i && i == f) ? i : e;
    end

endmodule

`default_nettype wire

### design/eagle2x_block_fifo.sv
`default_nettype none

module eagle2x_block_fifo #(
    parameter int DATA_BITS = 119
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire eagle2x_pkg::t_fifo_ctl                i_ctl,
    input  wire logic [DATA_BITS-1:0]                  i_data0,
    input  wire logic [DATA_BITS-1:0]                  i_data1,
    output logic      [DATA_BITS-1:0]                  o_data,
    output logic                                       o_valid,
    output logic      [eagle2x_pkg::FIFO_CNT_BITS-1:0] o_count
);

    localparam int AW = $clog2(eagle2x_pkg::FIFO_DEPTH);
    localparam int CW = eagle2x_pkg::FIFO_CNT_BITS;

    logic [DATA_BITS-1:0] r_mem [eagle2x_pkg::FIFO_DEPTH];
    logic [AW-1:0]        r_wp;
    logic [AW-1:0]        r_rp;
    logic [CW-1:0]        r_count;
    logic [AW-1:0]        n_wp;
    logic [AW-1:0]        n_rp;
    logic [CW-1:0]        n_count;

    always_comb begin
        n_wp    = AW'(r_wp + AW'(i_ctl.push_count));
        n_rp    = AW'(r_rp + AW'(i_ctl.pop));
        n_count = CW'(r_count + CW'(i_ctl.push_count) - CW'(i_ctl.pop));
    end

    // up to two entries go in per cycle, the second behind the first
    always_ff @(posedge i_clk) begin
        if (i_ctl.push_count != 2'd0) begin
            r_mem[r_wp] <= i_data0;
        end
        if (i_ctl.push_count == 2'd2) begin
            r_mem[AW'(r_wp + 1'b1)] <= i_data1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    assign o_data  = r_mem[r_rp];
    assign o_valid = (r_count != '0);
    assign o_count = r_count;

endmodule

`default_nettype wire

### design/eagle_2x_pixel_upscaler.sv
// Eagle 2x pixel-art upscaler.
// Slave stream: one source pixel per transfer in raster order, tuser = 0, pixel in tdata.
// After the last pixel of a frame the source sends flush transfers (tuser = 1), one per
// column, that drive out the bottom row of blocks. Pixels during the flush and flushes
// before the frame is complete are taken and dropped.
// Master stream: one 2x2 block per transfer, tlast marks the last block of the frame.
// A pixel of row r >= 1 that is not in column 0 yields the block above-left of it, and
// the last pixel of a row r >= 1 yields the block above it too, so a row end gives two
// blocks unless the frame is one column wide. Throughput: one input transfer per clock
// while tready is high. The line stores are read at the transfer edge (one read per port
// per cycle), the block is formed from the read data in the next cycle and put into an
// 8-entry result queue. tready falls only when the queue could not take two more blocks
// beyond those of the transfer in stage 1; when the receiver stalls, the queue fills and
// the slave side stops.
// Reset clears counters, flush state and the queue and loads width min(1024, MAX_WIDTH)
// and height 1024; line stores are not cleared. A configuration write restarts the frame.
`default_nettype none

module eagle_2x_pixel_upscaler #(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 24
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // configuration write port
    input  wire logic                                  i_cfg_we,
    input  wire logic [eagle2x_pkg::CFG_ADDR_BITS-1:0] i_cfg_addr,
    input  wire logic [eagle2x_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    // source pixels
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    input  wire logic [(PIXEL_BITS+7)/8*8-1:0]         s_axis_tdata,  // pixel
    input  wire logic                                  s_axis_tuser,  // opcode
    // output blocks
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    // top_left, top_right, bottom_left, bottom_right, block_column, block_row
    output logic [(4*PIXEL_BITS+eagle2x_pkg::COL_BITS+eagle2x_pkg::ROW_BITS+7)/8*8-1:0]
                                                       m_axis_tdata,
    output logic                                       m_axis_tlast   // frame_done
);

    localparam int PB     = PIXEL_BITS;
    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int RB     = eagle2x_pkg::ROW_BITS;
    localparam int CB     = eagle2x_pkg::COL_BITS;
    localparam int NC     = eagle2x_pkg::NUM_CORNERS;
    localparam int EW     = NC * PB + CB + RB + 1;
    localparam int OUT_TW = (NC * PB + CB + RB + 7) / 8 * 8;
    localparam int RESET_W = (eagle2x_pkg::WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH
                                                                    : eagle2x_pkg::WIDTH_RESET;
    localparam logic [CW-1:0] RESET_W_LAST = CW'(RESET_W - 1);
    localparam logic [RB-1:0] RESET_H_LAST = RB'(eagle2x_pkg::HEIGHT_RESET - 1);

    // frame geometry and position
    logic [CW-1:0] r_w_last;
    logic [RB-1:0] r_h_last;
    logic [CW-1:0] r_col;
    logic [RB-1:0] r_row;
    logic [CW-1:0] r_fcount;
    logic          r_flushing;
    logic [CW-1:0] n_col;
    logic [RB-1:0] n_row;
    logic [CW-1:0] n_fcount;
    logic          n_flushing;

    logic [eagle2x_pkg::WIDTH_REG_BITS-1:0]  cfg_w;
    logic [eagle2x_pkg::HEIGHT_REG_BITS-1:0] cfg_h;
    logic [CW-1:0] cfg_w_last;
    logic [RB-1:0] cfg_h_last;

    logic          take;
    logic          pix_go;
    logic          fl_go;
    logic          col_at_end;
    logic          fl_at_end;
    logic [PB-1:0] in_pixel;

    // stage 1: line store data is back
    logic          r_s1_pix;
    logic          r_s1_fl;
    logic [PB-1:0] r_s1_px;
    logic [CW-1:0] r_s1_c;
    logic [RB-1:0] r_s1_r;
    logic          r_s1_bank;
    logic          r_s1_top_mid;
    logic          r_s1_emit_a;
    logic          r_s1_emit_b;
    logic          r_s1_c_is1;
    logic          r_s1_w_is1;
    logic          r_s1_f_is0;
    logic          r_s1_done;

    logic [CW-1:0] rd_addr_a;
    logic [CW-1:0] rd_addr_b;
    logic [PB-1:0] rd0_a, rd0_b, rd1_a, rd1_b;

    logic [2:0][2:0][PB-1:0] r_win;
    logic [2:0][2:0][PB-1:0] n_win;
    logic [PB-1:0] px_up, px_mid;

    logic [PB-1:0] fl_mid_f, fl_top_f, fl_mid_r, fl_top_r;
    logic [PB-1:0] r_fl_prev_top, r_fl_prev_mid;
    logic          h_is1;

    logic [2:0][2:0][PB-1:0] nb_a, nb_b;
    logic [NC-1:0][PB-1:0]   corners_a, corners_b;

    logic [CB-1:0] col_a, col_b;
    logic [RB-1:0] row_a, row_pix;
    logic          done_a;
    logic [EW-1:0] entry_a, entry_b;

    eagle2x_pkg::t_fifo_ctl fifo_ctl;
    logic [EW-1:0] fifo_d0;
    logic [EW-1:0] fifo_out;
    logic          fifo_valid;
    logic [eagle2x_pkg::FIFO_CNT_BITS-1:0] fifo_count;

    // ---------------- configuration ----------------

    assign cfg_w = i_cfg_data[eagle2x_pkg::WIDTH_REG_BITS-1:0];
    assign cfg_h = i_cfg_data[eagle2x_pkg::HEIGHT_REG_BITS-1:0];

    // out-of-range width and height are clamped into the legal range
    always_comb begin
        if (cfg_w == '0) begin
            cfg_w_last = '0;
        end else if (32'(cfg_w) > 32'(MAX_WIDTH)) begin
            cfg_w_last = CW'(MAX_WIDTH - 1);
        end else begin
            cfg_w_last = CW'(32'(cfg_w) - 32'd1);
        end
        if (cfg_h == '0) begin
            cfg_h_last = '0;
        end else if (32'(cfg_h) > 32'(eagle2x_pkg::HEIGHT_MAX)) begin
            cfg_h_last = RB'(eagle2x_pkg::HEIGHT_MAX - 1);
        end else begin
            cfg_h_last = RB'(32'(cfg_h) - 32'd1);
        end
    end

    // ---------------- input side ----------------

    assign in_pixel   = s_axis_tdata[PB-1:0];
    assign take       = s_axis_tvalid & s_axis_tready;
    assign pix_go     = take & (s_axis_tuser == eagle2x_pkg::OP_PIXEL) & ~r_flushing;
    assign fl_go      = take & (s_axis_tuser == eagle2x_pkg::OP_FLUSH) & r_flushing;
    assign col_at_end = (r_col == r_w_last);
    assign fl_at_end  = (r_fcount == r_w_last);

    always_comb begin
        n_col      = r_col;
        n_row      = r_row;
        n_fcount   = r_fcount;
        n_flushing = r_flushing;
        if (pix_go) begin
            if (col_at_end) begin
                n_col = '0;
                if (r_row >= r_h_last) begin
                    n_flushing = 1'b1;
                    n_fcount   = '0;
                end else begin
                    n_row = RB'(r_row + 1'b1);
                end
            end else begin
                n_col = CW'(r_col + 1'b1);
            end
        end else if (fl_go) begin
            if (fl_at_end) begin
                n_col      = '0;
                n_row      = '0;
                n_fcount   = '0;
                n_flushing = 1'b0;
            end else begin
                n_fcount = CW'(r_fcount + 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_last   <= RESET_W_LAST;
            r_h_last   <= RESET_H_LAST;
            r_col      <= '0;
            r_row      <= '0;
            r_fcount   <= '0;
            r_flushing <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                eagle2x_pkg::REG_FRAME_WIDTH: begin
                    r_w_last <= cfg_w_last;
                end
                eagle2x_pkg::REG_FRAME_HEIGHT: begin
                    r_h_last <= cfg_h_last;
                end
                default: begin
                    r_w_last <= r_w_last;
                end
            endcase
            r_col      <= '0;
            r_row      <= '0;
            r_fcount   <= '0;
            r_flushing <= 1'b0;
        end else begin
            r_col      <= n_col;
            r_row      <= n_row;
            r_fcount   <= n_fcount;
            r_flushing <= n_flushing;
        end
    end

    // ---------------- line stores ----------------
    // rows alternate between the two banks: row r goes to bank r[0], so the bank being
    // written holds row r-2 and the other bank row r-1

    assign rd_addr_a = r_flushing ? r_fcount : r_col;
    assign rd_addr_b = fl_at_end ? r_fcount : CW'(r_fcount + 1'b1);

    eagle2x_line_ram #(
        .DEPTH     (MAX_WIDTH),
        .DATA_BITS (PB)
    ) u_bank0 (
        .i_clk     (i_clk),
        .i_we      (pix_go & ~r_row[0]),
        .i_waddr   (r_col),
        .i_wdata   (in_pixel),
        .i_raddr_a (rd_addr_a),
        .i_raddr_b (rd_addr_b),
        .o_rdata_a (rd0_a),
        .o_rdata_b (rd0_b)
    );

    eagle2x_line_ram #(
        .DEPTH     (MAX_WIDTH),
        .DATA_BITS (PB)
    ) u_bank1 (
        .i_clk     (i_clk),
        .i_we      (pix_go & r_row[0]),
        .i_waddr   (r_col),
        .i_wdata   (in_pixel),
        .i_raddr_a (rd_addr_a),
        .i_raddr_b (rd_addr_b),
        .o_rdata_a (rd1_a),
        .o_rdata_b (rd1_b)
    );

    // ---------------- stage 1 ----------------

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_pix <= 1'b0;
            r_s1_fl  <= 1'b0;
        end else begin
            r_s1_pix <= pix_go;
            r_s1_fl  <= fl_go;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_px      <= in_pixel;
        r_s1_c       <= r_flushing ? r_fcount : r_col;
        r_s1_r       <= r_row;
        r_s1_bank    <= r_row[0];
        r_s1_top_mid <= (r_row <= RB'(1));
        r_s1_emit_a  <= (r_row != '0) && (r_col != '0);
        r_s1_emit_b  <= (r_row != '0) && col_at_end;
        r_s1_c_is1   <= (r_col == CW'(1));
        r_s1_w_is1   <= (r_w_last == '0);
        r_s1_f_is0   <= (r_fcount == '0);
        r_s1_done    <= fl_at_end;
    end

    // pixel path: shift the window one column and load the new column
    assign px_up  = r_s1_bank ? rd1_a : rd0_a;
    assign px_mid = r_s1_bank ? rd0_a : rd1_a;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_win[k][0] = r_win[k][1];
            n_win[k][1] = r_win[k][2];
        end
        n_win[0][2] = r_s1_top_mid ? px_mid : px_up;
        n_win[1][2] = px_mid;
        n_win[2][2] = r_s1_px;
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_pix) begin
            r_win <= n_win;
        end
    end

    // flush path: last row is in bank h-1 parity, the row above it in the other bank
    assign h_is1    = (r_h_last == '0);
    assign fl_mid_f = r_h_last[0] ? rd1_a : rd0_a;
    assign fl_mid_r = r_h_last[0] ? rd1_b : rd0_b;
    assign fl_top_f = h_is1 ? fl_mid_f : (r_h_last[0] ? rd0_a : rd1_a);
    assign fl_top_r = h_is1 ? fl_mid_r : (r_h_last[0] ? rd0_b : rd1_b);

    always_ff @(posedge i_clk) begin
        if (r_s1_fl) begin
            r_fl_prev_top <= fl_top_f;
            r_fl_prev_mid <= fl_mid_f;
        end
    end

    // neighbourhoods: the first kernel serves flushes and the up-left block, the second
    // the block above a row-end pixel
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            nb_b[k][0] = r_s1_w_is1 ? n_win[k][2] : n_win[k][1];
            nb_b[k][1] = n_win[k][2];
            nb_b[k][2] = n_win[k][2];
        end
        if (r_s1_fl) begin
            nb_a[0][0] = r_s1_f_is0 ? fl_top_f : r_fl_prev_top;
            nb_a[1][0] = r_s1_f_is0 ? fl_mid_f : r_fl_prev_mid;
            nb_a[2][0] = r_s1_f_is0 ? fl_mid_f : r_fl_prev_mid;
            nb_a[0][1] = fl_top_f;
            nb_a[1][1] = fl_mid_f;
            nb_a[2][1] = fl_mid_f;
            nb_a[0][2] = fl_top_r;
            nb_a[1][2] = fl_mid_r;
            nb_a[2][2] = fl_mid_r;
        end else begin
            for (int k = 0; k < 3; k++) begin
                nb_a[k][0] = r_s1_c_is1 ? n_win[k][1] : n_win[k][0];
                nb_a[k][1] = n_win[k][1];
                nb_a[k][2] = n_win[k][2];
            end
        end
    end

    eagle2x_kernel #(
        .PIXEL_BITS (PB)
    ) u_kernel_a (
        .i_nb     (nb_a),
        .o_corner (corners_a)
    );

    eagle2x_kernel #(
        .PIXEL_BITS (PB)
    ) u_kernel_b (
        .i_nb     (nb_b),
        .o_corner (corners_b)
    );

    // ---------------- result queue ----------------

    assign row_pix = RB'(r_s1_r - 1'b1);
    assign col_a   = r_s1_fl ? CB'(r_s1_c) : CB'(CW'(r_s1_c - 1'b1));
    assign col_b   = CB'(r_s1_c);
    assign row_a   = r_s1_fl ? r_h_last : row_pix;
    assign done_a  = r_s1_fl & r_s1_done;

    assign entry_a = {done_a, row_a, col_a, corners_a};
    assign entry_b = {1'b0, row_pix, col_b, corners_b};

    always_comb begin
        fifo_ctl.pop = m_axis_tvalid & m_axis_tready;
        if (r_s1_fl) begin
            fifo_ctl.push_count = 2'd1;
        end else if (r_s1_pix) begin
            fifo_ctl.push_count = 2'(r_s1_emit_a) + 2'(r_s1_emit_b);
        end else begin
            fifo_ctl.push_count = 2'd0;
        end
    end

    assign fifo_d0 = (r_s1_fl || r_s1_emit_a) ? entry_a : entry_b;

    eagle2x_block_fifo #(
        .DATA_BITS (EW)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (fifo_ctl),
        .i_data0 (fifo_d0),
        .i_data1 (entry_b),
        .o_data  (fifo_out),
        .o_valid (fifo_valid),
        .o_count (fifo_count)
    );

    // room for the results of the transfer in stage 1 and of the one taken now
    assign s_axis_tready = (32'(fifo_count) + 32'(fifo_ctl.push_count))
                           <= 32'(eagle2x_pkg::FIFO_DEPTH - 2);

    assign m_axis_tvalid = fifo_valid;
    assign m_axis_tdata  = OUT_TW'(fifo_out[EW-2:0]);
    assign m_axis_tlast  = fifo_out[EW-1];

endmodule

`default_nettype wire
